FILE: rtl/catseq_pkg.sv
// ----------------------------------------------------------------------------
// catseq_pkg
// shared constants for the catalan sequence generator mod p
// ----------------------------------------------------------------------------
package catseq_pkg;

  // default width of the modulus datapath
  localparam int MOD_WIDTH_DEF = 31;

  // field widths
  localparam int MODULUS_W = 31;
  localparam int INDEX_W   = 8;
  localparam int VALUE_W   = 31;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS    = 1'b0,
    REG_LAST_INDEX = 1'b1
  } cfg_reg_t;

  // stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

endpackage

FILE: rtl/catseq_mulmod.sv
// ----------------------------------------------------------------------------
// catseq_mulmod
// bit-serial modular multiplier, prod = x * y mod p, one bit of x per cycle
// ----------------------------------------------------------------------------
module catseq_mulmod #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W+1:0] x,     // any value, scanned msb first
  input  logic [W-1:0] y,     // must be below p
  input  logic [W-1:0] p,     // nonzero modulus
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int XW = W + 2;
  localparam int CW = $clog2(XW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [XW-1:0] x_r;
  logic [W-1:0]  acc_r;

  logic [W:0]   pe;
  logic [W:0]   dbl;
  logic [W:0]   dbl_red;
  logic [W:0]   addend;
  logic [W:0]   sum;
  logic [W:0]   sum_red;

  // double, reduce, conditionally add y, reduce
  always_comb begin
    pe      = {1'b0, p};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= pe) ? dbl - pe : dbl;
    addend  = x_r[XW-1] ? {1'b0, y} : '0;
    sum     = dbl_red + addend;
    sum_red = (sum >= pe) ? sum - pe : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= x;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= sum_red[W-1:0];
        x_r   <= {x_r[XW-2:0], 1'b0};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(XW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: rtl/signed_catalan_sequence_mod_p.sv
// ----------------------------------------------------------------------------
// signed_catalan_sequence_mod_p
// catalan numbers C(j) and signed coefficients kappa_j mod p, one index per
// request, inverse of (j+1) by square-and-multiply on a bit-serial multiplier
// ----------------------------------------------------------------------------
// cost: one request takes (4 + 2*ones(p-2) + zeros(p-2)) bit-serial multiplies
//   plus one sequencer step per exponent bit; a modulus of zero skips the
//   multiplier and queues a zero result directly
// throughput: one request at a time; the single bit-serial multiplier sets it
// a finished result waits in the output register while the next request runs
// reset: modulus 3, last index 1, sequence restarts at index 1 with C(0) = 1
// ----------------------------------------------------------------------------
module signed_catalan_sequence_mod_p #(
  parameter int MOD_WIDTH = catseq_pkg::MOD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_wen,
  input  logic [catseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [catseq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [catseq_pkg::IN_DATA_W-1:0]   in_tdata,   // [0] restart, rest zero
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [catseq_pkg::OUT_DATA_W-1:0]  out_tdata,  // [7:0] index, [38:8] kappa,
                                                         // [69:39] catalan, rest zero
  output logic                               out_tlast   // is_last
);

  import catseq_pkg::*;

  localparam int W  = MOD_WIDTH;
  localparam int XW = W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,       // reduce stored C(j-1) mod p
    S_SCALE,     // times 2*(2j-1)
    S_BASE,      // reduce j+1 mod p
    S_POW_DEC,   // pick next exponent step
    S_POW_MUL,   // acc *= base
    S_POW_SQR,   // base *= base
    S_FINAL      // catalan = scaled * inverse, then output
  } state_t;

  state_t state_r;
  logic   out_pend_r;   // result ready at S_FINAL exit or for a zero modulus, waiting for output slot

  // configuration registers
  logic [MODULUS_W-1:0] modulus_r;
  logic [INDEX_W-1:0]   last_index_r;

  // sequence state
  logic [W-1:0]       prev_catalan_r;
  logic [INDEX_W-1:0] next_index_r;

  // working registers
  logic [INDEX_W-1:0] j_r;
  logic [W-1:0]       c_r;       // C(j-1) mod p
  logic [W-1:0]       t_r;       // C(j-1)*2*(2j-1) mod p
  logic [W-1:0]       base_r;
  logic [W-1:0]       acc_r;
  logic [W-1:0]       ex_r;
  logic [W-1:0]       cat_r;

  // multiplier request
  logic          mul_start_r;
  logic [XW-1:0] mul_x_r;
  logic [W-1:0]  mul_y_r;
  logic          mul_done;
  logic [W-1:0]  mul_prod;

  // output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tlast_r;

  // derived values
  logic [31:0]        mod32;
  logic [W-1:0]       p;
  logic [W-1:0]       one_p;
  logic               p_zero;
  logic [INDEX_W-1:0] last_eff;
  logic               seq_restart;
  logic [INDEX_W-1:0] j_eff;
  logic [W-1:0]       prev_eff;
  logic [XW-1:0]      scale_x;
  logic [XW-1:0]      base_x;
  logic [W-1:0]       ex_init;
  logic [W-1:0]       kappa_w;
  logic [31:0]        kappa32;
  logic [31:0]        cat32;
  logic               fin;
  logic               in_acc;
  logic               out_free;

  always_comb begin
    mod32       = {1'b0, modulus_r};
    p           = mod32[W-1:0];
    p_zero      = (p == '0);
    // residue of 1, zero when p is one
    one_p       = (p == W'(1)) ? '0 : W'(1);
    // a last index of zero behaves as one
    last_eff    = (last_index_r == '0) ? INDEX_W'(1) : last_index_r;
    seq_restart = in_tdata[0] || (next_index_r > last_eff) || (next_index_r == '0);
    j_eff       = seq_restart ? INDEX_W'(1) : next_index_r;
    prev_eff    = seq_restart ? W'(1) : prev_catalan_r;
    scale_x     = XW'({j_r, 2'b00}) - XW'(2);
    base_x      = XW'(j_r) + XW'(1);
    ex_init     = (p >= W'(2)) ? p - W'(2) : '0;
    // odd index negates C(j-1)
    if (j_r[0]) begin
      kappa_w = (c_r == '0) ? '0 : p - c_r;
    end else begin
      kappa_w = c_r;
    end
    kappa32  = 32'(kappa_w);
    cat32    = 32'(cat_r);
    fin      = (j_r == last_eff);
    in_acc   = in_tvalid && in_tready;
    out_free = !out_tvalid_r || out_tready;
  end

  assign in_tready = (state_r == S_IDLE) && !out_pend_r;

  catseq_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .x     (mul_x_r),
    .y     (mul_y_r),
    .p     (p),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MODULUS_W'(3);
      last_index_r <= INDEX_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODULUS:    modulus_r    <= cfg_wdata[MODULUS_W-1:0];
        REG_LAST_INDEX: last_index_r <= cfg_wdata[INDEX_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_pend_r     <= 1'b0;
      mul_start_r    <= 1'b0;
      out_tvalid_r   <= 1'b0;
      prev_catalan_r <= W'(1);
      next_index_r   <= INDEX_W'(1);
    end else begin
      mul_start_r <= 1'b0;
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      // hand the finished result to the output register
      if (out_pend_r && out_free) begin
        out_pend_r   <= 1'b0;
        out_tvalid_r <= 1'b1;
        out_tlast_r  <= fin;
        out_tdata_r  <= {2'b00, cat32[30:0], kappa32[30:0], j_r};
        if (fin) begin
          next_index_r   <= INDEX_W'(1);
          prev_catalan_r <= W'(1);
        end else begin
          next_index_r   <= j_r + INDEX_W'(1);
          prev_catalan_r <= cat_r;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            j_r <= j_eff;
            if (p_zero) begin
              // every residue is zero
              c_r        <= '0;
              cat_r      <= '0;
              out_pend_r <= 1'b1;
            end else begin
              mul_start_r <= 1'b1;
              mul_x_r     <= XW'(prev_eff);
              mul_y_r     <= one_p;
              state_r     <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_done) begin
            c_r         <= mul_prod;
            mul_start_r <= 1'b1;
            mul_x_r     <= scale_x;
            mul_y_r     <= mul_prod;
            state_r     <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            t_r         <= mul_prod;
            mul_start_r <= 1'b1;
            mul_x_r     <= base_x;
            mul_y_r     <= one_p;
            state_r     <= S_BASE;
          end
        end
        S_BASE: begin
          if (mul_done) begin
            base_r  <= mul_prod;
            acc_r   <= one_p;
            ex_r    <= ex_init;
            state_r <= S_POW_DEC;
          end
        end
        S_POW_DEC: begin
          mul_start_r <= 1'b1;
          if (ex_r == '0) begin
            mul_x_r <= XW'(t_r);
            mul_y_r <= acc_r;
            state_r <= S_FINAL;
          end else if (ex_r[0]) begin
            mul_x_r <= XW'(acc_r);
            mul_y_r <= base_r;
            state_r <= S_POW_MUL;
          end else begin
            mul_x_r <= XW'(base_r);
            mul_y_r <= base_r;
            state_r <= S_POW_SQR;
          end
        end
        S_POW_MUL: begin
          if (mul_done) begin
            acc_r       <= mul_prod;
            mul_start_r <= 1'b1;
            mul_x_r     <= XW'(base_r);
            mul_y_r     <= base_r;
            state_r     <= S_POW_SQR;
          end
        end
        S_POW_SQR: begin
          if (mul_done) begin
            base_r  <= mul_prod;
            ex_r    <= ex_r >> 1;
            state_r <= S_POW_DEC;
          end
        end
        S_FINAL: begin
          if (mul_done) begin
            cat_r      <= mul_prod;
            out_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // an accepted request always starts work or queues a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE) || out_pend_r)
    else $error("accepted request did not start");

  // multiplier never finishes while the sequencer is idle
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r != S_IDLE))
    else $error("multiplier done outside an operation");

  // a held result agrees with the sequence state it left behind
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_pend_r |->
      (next_index_r == (out_tlast_r ? INDEX_W'(1) : out_tdata_r[7:0] + INDEX_W'(1))))
    else $error("next index out of step with output");

  // results never carry index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[7:0] != '0))
    else $error("zero index in result");

endmodule
